// ----- rtl/sliding_window_mean_core_macros.svh -----
// Assertion macros for the sliding window mean core.
// Clocked on clk, disabled while rst_n is low; no other dependencies.
`ifndef SLIDING_WINDOW_MEAN_CORE_MACROS_SVH
`define SLIDING_WINDOW_MEAN_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Check a consequence in the same cycle as its trigger.
`define SWM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swm assertion failed");
// Check a consequence in the cycle after its trigger.
`define SWM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swm assertion failed");
`else
`define SWM_ASSERT_NOW(lbl, ante, cons)
`define SWM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/swm_pkg.sv -----
// Shared types and constants for the sliding window mean core.
// No dependencies; imported by every module of the block.
`default_nettype none
package swm_pkg;

  // Configuration register width and reset value
  localparam int unsigned WS_BITS = 9;
  localparam logic [WS_BITS-1:0] WS_RESET = 9'd4;

  // Queue between the front and back sections
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_BITS = $clog2(QDEPTH);
  localparam int unsigned QCNT_BITS = $clog2(QDEPTH + 1);

  // Queue status seen by the producer and the consumer
  typedef struct packed {
    logic                 empty;
    logic [QCNT_BITS-1:0] count;
  } swm_qstat_t;

  // Divider sequencer states
  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_DIV  = 3'b010,
    BK_DONE = 3'b100
  } swm_bk_state_t;

endpackage
`default_nettype wire

// ----- rtl/swm_front.sv -----
// Front section: takes samples, keeps the sample store, fill count and window sum.
// Depends on swm_pkg; feeds finished window sums to swm_queue.
`default_nettype none
module swm_front
  import swm_pkg::*;
#(
  parameter int unsigned MAX_WINDOW  = 256,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned EW_BITS     = $clog2(MAX_WINDOW + 1),
  parameter int unsigned SUM_BITS    = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                          in_first,
  input  wire logic                          cfg_we,
  input  wire logic        [WS_BITS-1:0]     cfg_window_size,
  input  wire swm_qstat_t                    qstat,
  output logic                               q_push,
  output logic signed [SUM_BITS-1:0]         q_data,
  output logic             [EW_BITS-1:0]     eff_w
);

  localparam int unsigned PTR_BITS = $clog2(MAX_WINDOW);
  localparam int unsigned IDX_BITS = EW_BITS + 1;

  logic [WS_BITS-1:0]            cfg_r;
  logic [PTR_BITS-1:0]           wp_r, wp_nxt;
  logic [EW_BITS-1:0]            fill_r, fill_nxt, fill_base;
  logic signed [SUM_BITS-1:0]    sum_r, sum_nxt, sum_base, sum_sub;
  logic [SAMPLE_BITS-1:0]        store_m [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] rd_r;
  logic                          s1_valid_r, s1_produce_r, s1_sub_r, s1_first_r;
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  logic                          produce_nxt, sub_nxt;
  logic signed [IDX_BITS-1:0]    diff;
  logic [PTR_BITS-1:0]           old_idx;
  logic                          accept;

  assign accept = push && !full;

  // Hold off input while the queue could not take the result in flight
  assign full = ({1'b0, qstat.count} + (QCNT_BITS + 1)'(s1_valid_r & s1_produce_r))
                >= (QCNT_BITS + 1)'(QDEPTH);

  // Clamp the configured size to 1..MAX_WINDOW
  always_comb begin
    if (cfg_r == '0) begin
      eff_w = EW_BITS'(1);
    end else if (32'(cfg_r) > MAX_WINDOW) begin
      eff_w = EW_BITS'(MAX_WINDOW);
    end else begin
      eff_w = EW_BITS'(cfg_r);
    end
  end

  // Locate the sample that leaves the window, wrapping around the store
  always_comb begin
    diff = IDX_BITS'(wp_r) - IDX_BITS'(eff_w);
    if (diff[IDX_BITS-1]) begin
      old_idx = PTR_BITS'(diff + IDX_BITS'(MAX_WINDOW));
    end else begin
      old_idx = PTR_BITS'(diff);
    end
  end

  // Classify the incoming sample: still filling, completing, or sliding
  always_comb begin
    fill_base = in_first ? '0 : fill_r;
    if (fill_base < eff_w) begin
      fill_nxt    = fill_base + EW_BITS'(1);
      produce_nxt = (fill_nxt == eff_w);
      sub_nxt     = 1'b0;
    end else begin
      fill_nxt    = fill_base;
      produce_nxt = 1'b1;
      sub_nxt     = 1'b1;
    end
    wp_nxt = (32'(wp_r) == MAX_WINDOW - 1) ? '0 : wp_r + PTR_BITS'(1);
  end

  // Form the window sum from the store read in the cycle after it
  always_comb begin
    sum_base = s1_first_r ? '0 : sum_r;
    sum_sub  = s1_sub_r ? SUM_BITS'(rd_r) : '0;
    sum_nxt  = sum_base + SUM_BITS'(s1_sample_r) - sum_sub;
  end

  assign q_push = s1_valid_r && s1_produce_r;
  assign q_data = sum_nxt;

  // Sample store: write the new sample, read the leaving one
  always_ff @(posedge clk) begin
    if (accept) begin
      store_m[wp_r] <= in_sample;
      rd_r          <= store_m[old_idx];
    end
  end

  // Stage payload for the sum update
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample_r  <= in_sample;
      s1_produce_r <= produce_nxt;
      s1_sub_r     <= sub_nxt;
      s1_first_r   <= in_first;
    end
  end

  // Control state: config, pointer, fill count, running sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r      <= WS_RESET;
      wp_r       <= '0;
      fill_r     <= '0;
      sum_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      if (s1_valid_r) begin
        sum_r <= sum_nxt;
      end
      if (accept) begin
        wp_r   <= wp_nxt;
        fill_r <= fill_nxt;
      end
      // A new size starts a new series
      if (cfg_we) begin
        cfg_r  <= cfg_window_size;
        fill_r <= '0;
        sum_r  <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/swm_queue.sv -----
// Short queue of window sums between the front and back sections.
// Depends on swm_pkg for its depth and status type.
`default_nettype none
module swm_queue
  import swm_pkg::*;
#(
  parameter int unsigned DATA_BITS = 25
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_push,
  input  wire logic [DATA_BITS-1:0] q_wdata,
  input  wire logic                 q_pop,
  output logic      [DATA_BITS-1:0] q_rdata,
  output swm_qstat_t                qstat
);

  logic [DATA_BITS-1:0] ent_r [QDEPTH];
  logic [QPTR_BITS-1:0] rp_r, wp_r;
  logic [QCNT_BITS-1:0] cnt_r;

  assign q_rdata     = ent_r[rp_r];
  assign qstat.empty = (cnt_r == '0);
  assign qstat.count = cnt_r;

  // Store incoming sums
  always_ff @(posedge clk) begin
    if (q_push) begin
      ent_r[wp_r] <= q_wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r  <= '0;
      wp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (q_push) begin
        wp_r <= (32'(wp_r) == QDEPTH - 1) ? '0 : wp_r + QPTR_BITS'(1);
      end
      if (q_pop) begin
        rp_r <= (32'(rp_r) == QDEPTH - 1) ? '0 : rp_r + QPTR_BITS'(1);
      end
      if (q_push && !q_pop) begin
        cnt_r <= cnt_r + QCNT_BITS'(1);
      end else if (q_pop && !q_push) begin
        cnt_r <= cnt_r - QCNT_BITS'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/swm_back.sv -----
// Back section: divides each window sum by the window size, one quotient bit a cycle.
// Depends on swm_pkg; drains swm_queue and holds the output register.
`default_nettype none
module swm_back
  import swm_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned EW_BITS     = 9,
  parameter int unsigned SUM_BITS    = 25
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire swm_qstat_t                    qstat,
  input  wire logic signed [SUM_BITS-1:0]    q_rdata,
  output logic                               q_pop,
  input  wire logic        [EW_BITS-1:0]     eff_w,
  output logic                               empty,
  input  wire logic                          pop,
  output logic signed [SAMPLE_BITS-1:0]      out_average
);

  localparam int unsigned REM_BITS = EW_BITS + 1;
  localparam int unsigned CNT_BITS = $clog2(SUM_BITS + 1);

  swm_bk_state_t              state_r, state_nxt;
  logic [SUM_BITS-1:0]        quo_r, quo_nxt;
  logic [REM_BITS-1:0]        rem_r, rem_nxt, rem_sh;
  logic [CNT_BITS-1:0]        cnt_r;
  logic                       neg_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_r, res;
  logic                       ge;
  logic                       load_out;

  assign empty       = !out_valid_r;
  assign out_average = out_r;
  assign q_pop       = (state_r == BK_IDLE) && !qstat.empty;
  assign load_out    = (state_r == BK_DONE) && (!out_valid_r || pop);

  // One restoring division step
  always_comb begin
    rem_sh  = {rem_r[REM_BITS-2:0], quo_r[SUM_BITS-1]};
    ge      = (rem_sh >= REM_BITS'(eff_w));
    rem_nxt = ge ? rem_sh - REM_BITS'(eff_w) : rem_sh;
    quo_nxt = {quo_r[SUM_BITS-2:0], ge};
  end

  // Restore the sign; the mean always fits a sample
  assign res = neg_r ? -$signed(quo_r[SAMPLE_BITS-1:0]) : $signed(quo_r[SAMPLE_BITS-1:0]);

  // Sequence: load, iterate, hand off
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (!qstat.empty) state_nxt = BK_DIV;
      BK_DIV:  if (cnt_r == CNT_BITS'(1)) state_nxt = BK_DONE;
      BK_DONE: if (load_out) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Divider datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      neg_r <= q_rdata[SUM_BITS-1];
      quo_r <= q_rdata[SUM_BITS-1] ? SUM_BITS'(-q_rdata) : SUM_BITS'(q_rdata);
      rem_r <= '0;
      cnt_r <= CNT_BITS'(SUM_BITS);
    end else if (state_r == BK_DIV) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - CNT_BITS'(1);
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= res;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sliding_window_mean_core.sv -----
// Sliding window mean (boxcar moving average) over signed samples.
// Usage:
//   Input: drive in_sample/in_first with push; a transfer happens when push is
//   high and full is low. in_first starts a new series (fill count and sum clear).
//   Output: while empty is low, out_average holds the oldest mean; pop transfers it.
//   Config: cfg_we with cfg_window_size sets the window (0 acts as 1, sizes above
//   MAX_WINDOW saturate) and starts a new series; write only while idle.
// Timing:
//   No result until a series has window_size samples; then one mean per sample.
//   Samples that give no result are taken one per cycle while full is low. Each
//   mean goes through a shared bit-serial divider, which sets the sustained result
//   rate. From an input transfer, a mean passes the sum update stage, the queue,
//   the divider and the output register before empty goes low.
//   A two-entry queue separates the sum update from the divider, so samples keep
//   flowing while the divider works until the queue fills and full is raised.
// Reset: synchronous, active low; window size returns to 4, series restarts,
//   queue and output empty. Sample store contents are not cleared.
// Stall: if pop stays low, the finished mean waits in the output register, the
//   divider holds its next result, and full rises once the queue backs up.
`default_nettype none
module sliding_window_mean_core
  import swm_pkg::*;
#(
  parameter int unsigned MAX_WINDOW  = 256,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                          in_first,
  output logic                               empty,
  input  wire logic                          pop,
  output logic signed [SAMPLE_BITS-1:0]      out_average,
  input  wire logic                          cfg_we,
  input  wire logic        [WS_BITS-1:0]     cfg_window_size
);

`include "sliding_window_mean_core_macros.svh"

  localparam int unsigned EW_BITS  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;

  swm_qstat_t                 qstat;
  logic                       q_push, q_pop;
  logic signed [SUM_BITS-1:0] q_wdata, q_rdata;
  logic [EW_BITS-1:0]         eff_w;

  // Accept and accumulate
  swm_front #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .EW_BITS     (EW_BITS),
    .SUM_BITS    (SUM_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_sample       (in_sample),
    .in_first        (in_first),
    .cfg_we          (cfg_we),
    .cfg_window_size (cfg_window_size),
    .qstat           (qstat),
    .q_push          (q_push),
    .q_data          (q_wdata),
    .eff_w           (eff_w)
  );

  // Decouple sum update from division
  swm_queue #(
    .DATA_BITS (SUM_BITS)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .qstat   (qstat)
  );

  // Divide and present
  swm_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .EW_BITS     (EW_BITS),
    .SUM_BITS    (SUM_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .qstat       (qstat),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .eff_w       (eff_w),
    .empty       (empty),
    .pop         (pop),
    .out_average (out_average)
  );

  // Queue never overflows: full accounts for the sum in flight
  `SWM_ASSERT_NOW(a_q_no_overflow, q_push, (32'(qstat.count) < QDEPTH))
  // Divider only drains a queue that holds a sum
  `SWM_ASSERT_NOW(a_q_no_underflow, q_pop, !qstat.empty)
  // A pushed sum is visible to the divider next cycle
  `SWM_ASSERT_NEXT(a_q_push_seen, q_push, !qstat.empty)

endmodule
`default_nettype wire

// ----- tb/sliding_window_mean_core_tb.sv -----
// Testbench for sliding_window_mean_core: random and directed sample streams with a
// scoreboard that predicts every window mean. Depends on swm_pkg and the core RTL.
module sliding_window_mean_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import swm_pkg::*;

  localparam int unsigned MAX_WIN     = 256;
  localparam int unsigned SAMPLE_W    = 16;
  // Covers the divider's work on a sum; leave some margin
  localparam int unsigned SETTLE      = 40;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned TX_IDLE_A   = 21;
  localparam int unsigned RX_IDLE_A   = 84;
  localparam int unsigned NO_IDLE     = 0;

  // Window mean predictor and store of expected means
  class swm_mean_scoreboard;
    logic signed [SAMPLE_W-1:0] sample_hist [MAX_WIN];
    logic [7:0]                 wr_ptr;
    int unsigned                fill_cnt;
    longint                     window_sum;
    logic [WS_BITS-1:0]         win_reg;
    logic signed [SAMPLE_W-1:0] pending_means [$];
    int unsigned                mismatches;

    function new();
      wr_ptr      = '0;
      fill_cnt    = 0;
      window_sum  = 0;
      win_reg     = WS_RESET;
      mismatches  = 0;
    endfunction

    // Zero acts as one, oversize saturates
    function int unsigned eff_window();
      if (win_reg == 0) return 1;
      if (win_reg > MAX_WIN) return MAX_WIN;
      return win_reg;
    endfunction

    // A register write also restarts the series
    function void set_window(logic [WS_BITS-1:0] v);
      win_reg    = v;
      fill_cnt   = 0;
      window_sum = 0;
    endfunction

    function int unsigned pending();
      return pending_means.size();
    endfunction

    // Advance the window by one accepted sample and queue its mean, if any
    function void predict_mean(logic signed [SAMPLE_W-1:0] x, logic first);
      int unsigned w;
      int unsigned old_idx;
      longint      mean;
      bit          produced;
      w        = eff_window();
      produced = 1'b0;
      if (first) begin
        fill_cnt   = 0;
        window_sum = 0;
      end
      if (fill_cnt < w) begin
        window_sum += longint'(x);
        fill_cnt++;
        produced = (fill_cnt == w);
      end else begin
        old_idx     = (wr_ptr + MAX_WIN - w) % MAX_WIN;
        window_sum += longint'(x) - longint'(sample_hist[old_idx]);
        produced    = 1'b1;
      end
      sample_hist[wr_ptr] = x;
      wr_ptr++;
      if (produced) begin
        mean = window_sum / longint'(w);
        pending_means = {pending_means, mean[SAMPLE_W-1:0]};
      end
    endfunction

    // Compare one popped mean with the oldest expectation
    function void check_mean(logic signed [SAMPLE_W-1:0] got);
      logic signed [SAMPLE_W-1:0] exp_mean;
      if (pending_means.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected mean, expected none, actual %0d", $time, got);
        return;
      end
      exp_mean = pending_means.pop_front();
      if (got !== exp_mean) begin
        mismatches++;
        $display("%0t: average mismatch, expected %0d, actual %0d", $time, exp_mean, got);
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       push = 1'b0;
  logic                       full;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                       in_first = 1'b0;
  logic                       empty;
  logic                       pop = 1'b0;
  logic signed [SAMPLE_W-1:0] out_average;
  logic                       cfg_we = 1'b0;
  logic [WS_BITS-1:0]         cfg_window_size = '0;

  swm_mean_scoreboard sb = new();
  int unsigned        tx_idle_pct = 0;
  int unsigned        rx_idle_pct = 0;
  int unsigned        hold_req = 0;
  int unsigned        cycle_count = 0;

  sliding_window_mean_core #(
    .MAX_WINDOW (MAX_WIN),
    .SAMPLE_BITS(SAMPLE_W)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_sample      (in_sample),
    .in_first       (in_first),
    .empty          (empty),
    .pop            (pop),
    .out_average    (out_average),
    .cfg_we         (cfg_we),
    .cfg_window_size(cfg_window_size)
  );

  always #6 clk = ~clk;

  // Bias samples toward the extremes and toward small values near zero
  function logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return SAMPLE_W'($signed($urandom_range(8)) - 4);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  // Offer one sample, idling first at random, and hold it until the transfer
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic f);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    in_sample <= s;
    in_first  <= f;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.predict_mean(s, f);
  endtask

  // Stop sending and wait until every expected mean has been popped
  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_window(input logic [WS_BITS-1:0] v);
    drain();
    cfg_we          <= 1'b1;
    cfg_window_size <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_window(v);
  endtask

  // Mostly complete series with random content; some cut short by a restart
  task automatic send_stream(input int unsigned n);
    int unsigned w;
    int unsigned sent;
    int unsigned len;
    int unsigned j;
    bit          cut;
    w    = sb.eff_window();
    sent = 0;
    while (sent < n) begin
      cut = (w <= 64) && ($urandom_range(9) == 0);
      len = cut ? $urandom_range(w, 1) : w + $urandom_range(2 * w + 8);
      for (j = 0; j < len && sent < n; j++) begin
        send_sample(pick_sample(), j == 0);
        sent++;
      end
    end
  endtask

  task automatic run_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                           input bit long_hold, input bit big_window,
                           input logic [WS_BITS-1:0] big_size);
    int unsigned k;
    logic [WS_BITS-1:0] ws;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (k = 0; k < 4; k++) begin
      case ($urandom_range(3))
        0: ws = WS_BITS'($urandom_range(3));
        1: ws = WS_BITS'($urandom_range(16, 4));
        2: ws = WS_BITS'($urandom_range(40, 17));
        default: ws = WS_BITS'(1);
      endcase
      write_window(ws);
      // Starve the output so the queue backs up and full rises
      if (long_hold && k == 0) hold_req = LONG_HOLD;
      send_stream(50);
    end
    if (big_window) begin
      write_window(big_size);
      send_stream(265);
    end
  endtask

  // Result side: check each transfer, then pick the next pop
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) sb.check_mean(out_average);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog on total cycles
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes at the reset window of four, restart mid-window
    send_sample(16'sh7fff, 1'b1);
    repeat (3) send_sample(16'sh7fff, 1'b0);
    repeat (4) send_sample(16'sh8000, 1'b0);
    send_sample(-16'sd1, 1'b1);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd2, 1'b0);
    send_sample(-16'sd7, 1'b0);
    send_sample(16'sd9, 1'b0);
    send_sample(16'sd3, 1'b1);

    // Window size zero behaves as one
    write_window(9'd0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(-16'sd5, 1'b1);

    // A register write restarts a partly filled series
    write_window(9'd3);
    send_sample(16'sd100, 1'b0);
    send_sample(16'sd200, 1'b0);
    write_window(9'd3);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd2, 1'b0);
    send_sample(16'sd4, 1'b0);
    send_sample(-16'sd7, 1'b0);

    // Random: full window, oversize window saturating to the maximum
    run_phase(TX_IDLE_A, RX_IDLE_A, 1'b1, 1'b1, 9'd256);
    run_phase(RX_IDLE_A, TX_IDLE_A, 1'b0, 1'b0, 9'd0);
    run_phase(NO_IDLE, NO_IDLE, 1'b0, 1'b1, 9'd511);

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
